>>> rtl/core/clews_pkg.sv
// shared types, codes and init tables for the character lcd expander write sequencer
// used by clews_front, clews_fifo, clews_back and the top level; no dependencies
package clews_pkg;

	// request type codes on the input channel
	localparam logic [2:0] REQ_INIT      = 3'd0;
	localparam logic [2:0] REQ_CHAR      = 3'd1;
	localparam logic [2:0] REQ_CURSOR    = 3'd2;
	localparam logic [2:0] REQ_CLEAR     = 3'd3;
	localparam logic [2:0] REQ_BACKLIGHT = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_POWERUP    = 3'd0;
	localparam logic [2:0] CFG_FIRST_INIT = 3'd1;
	localparam logic [2:0] CFG_LATER_INIT = 3'd2;
	localparam logic [2:0] CFG_ENABLE     = 3'd3;
	localparam logic [2:0] CFG_EXEC       = 3'd4;
	localparam logic [2:0] CFG_CLEAR      = 3'd5;

	// configuration reset values
	localparam logic [15:0] RST_POWERUP    = 16'd50000;
	localparam logic [15:0] RST_FIRST_INIT = 16'd5000;
	localparam logic [15:0] RST_LATER_INIT = 16'd150;
	localparam logic [7:0]  RST_ENABLE     = 8'd1;
	localparam logic [15:0] RST_EXEC       = 16'd50;
	localparam logic [15:0] RST_CLEAR      = 16'd2000;

	// lcd command bytes
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] BL_ONLY_BYTE  = 8'h08;

	// last step index of each sequence
	localparam logic [4:0] BYTE_LAST_STEP = 5'd3;
	localparam logic [4:0] INIT_LAST_STEP = 5'd28;

	typedef enum logic [1:0] {
		KIND_INIT = 2'd0,
		KIND_BYTE = 2'd1,
		KIND_BL   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		EXTRA_NONE  = 3'd0,
		EXTRA_EXEC  = 3'd1,
		EXTRA_CLEAR = 3'd2,
		EXTRA_FIRST = 3'd3,
		EXTRA_LATER = 3'd4
	} extra_t;

	// classified request handed from front to back
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       rs;
		extra_t     extra;
		logic       bl;
	} desc_t;

	typedef struct packed {
		logic [15:0] powerup;
		logic [15:0] first_init;
		logic [15:0] later_init;
		logic [7:0]  enable_pulse;
		logic [15:0] exec;
		logic [15:0] clear;
	} cfg_t;

	// nibble sent at each nibble slot of the init sequence
	function automatic logic [3:0] init_nibble(input logic [3:0] idx);
		logic [3:0] nib;
		unique case (idx)
			4'd0, 4'd1, 4'd2: nib = 4'h3;
			4'd3, 4'd4:       nib = 4'h2;
			4'd5, 4'd7:       nib = 4'h8;
			4'd9:             nib = 4'h1;
			4'd11:            nib = 4'h6;
			4'd13:            nib = 4'hC;
			default:          nib = 4'h0;
		endcase
		return nib;
	endfunction

	// extra wait after the enable-low write of each init nibble slot
	function automatic extra_t init_extra(input logic [3:0] idx);
		extra_t ex;
		unique case (idx)
			4'd0:                       ex = EXTRA_FIRST;
			4'd1, 4'd2, 4'd3:           ex = EXTRA_LATER;
			4'd5, 4'd7, 4'd11, 4'd13:   ex = EXTRA_EXEC;
			4'd9:                       ex = EXTRA_CLEAR;
			default:                    ex = EXTRA_NONE;
		endcase
		return ex;
	endfunction

endpackage

>>> rtl/core/clews_front.sv
// front end: accepts requests and classifies them into sequencer descriptors
// depends on clews_pkg
module clews_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         req_type,
	input  logic [7:0]         char_code,
	input  logic [5:0]         column,
	input  logic               row,
	input  logic               backlight_on,
	input  logic               q_ready,
	output logic               q_push,
	output clews_pkg::desc_t   q_desc
);

	logic known;

	always_comb begin
		known        = 1'b1;
		q_desc.kind  = clews_pkg::KIND_BYTE;
		q_desc.data  = char_code;
		q_desc.rs    = 1'b0;
		q_desc.extra = clews_pkg::EXTRA_NONE;
		q_desc.bl    = backlight_on;
		unique case (req_type)
			clews_pkg::REQ_INIT: begin
				q_desc.kind = clews_pkg::KIND_INIT;
			end
			clews_pkg::REQ_CHAR: begin
				q_desc.rs = 1'b1;
			end
			clews_pkg::REQ_CURSOR: begin
				// column is below 0x40, so adding 0x40 for row one is an or
				q_desc.data  = clews_pkg::CMD_SET_DDRAM | {1'b0, row, column};
				q_desc.extra = clews_pkg::EXTRA_EXEC;
			end
			clews_pkg::REQ_CLEAR: begin
				q_desc.data  = clews_pkg::CMD_CLEAR;
				q_desc.extra = clews_pkg::EXTRA_CLEAR;
			end
			clews_pkg::REQ_BACKLIGHT: begin
				q_desc.kind = clews_pkg::KIND_BL;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// unknown types are taken and dropped
	assign in_ready = q_ready;
	assign q_push   = in_valid & q_ready & known;

endmodule

>>> rtl/core/clews_fifo.sv
// two-entry descriptor queue between front and back
// depends on clews_pkg
module clews_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  clews_pkg::desc_t   push_desc,
	output logic               ready,
	input  logic               pop,
	output logic               valid,
	output clews_pkg::desc_t   head
);

	clews_pkg::desc_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign ready = (count_q != 2'd2);
	assign valid = (count_q != 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/core/clews_back.sv
// back end: steps through each descriptor, one expander write per cycle while the output is not stalled
// depends on clews_pkg; holds the backlight state and the output register
module clews_back (
	input  logic               clk,
	input  logic               arst_n,
	input  clews_pkg::cfg_t    cfg,
	input  logic               q_valid,
	input  clews_pkg::desc_t   q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         expander_byte,
	output logic [15:0]        wait_before_us,
	output logic [16:0]        wait_after_us,
	output logic               last
);

	logic [4:0]        step_q;
	logic              bl_q;
	logic              out_valid_q;
	logic [7:0]        byte_q;
	logic [15:0]       before_q;
	logic [16:0]       after_q;
	logic              last_q;

	logic              advance;
	logic [3:0]        idx;
	logic              enable_w;
	logic [3:0]        nib;
	logic              rs;
	clews_pkg::extra_t extra;
	logic [15:0]       extra_val;
	logic [16:0]       nib_after;
	logic              bare_w;
	logic [7:0]        byte_d;
	logic [15:0]       before_d;
	logic [16:0]       after_d;
	logic              last_d;
	logic              bl_d;

	assign advance  = q_valid & (~out_valid_q | out_ready);
	assign q_pop    = advance & last_d;
	assign idx      = step_q[4:1];
	assign enable_w = ~step_q[0];

	always_comb begin
		unique case (extra)
			clews_pkg::EXTRA_EXEC:  extra_val = cfg.exec;
			clews_pkg::EXTRA_CLEAR: extra_val = cfg.clear;
			clews_pkg::EXTRA_FIRST: extra_val = cfg.first_init;
			clews_pkg::EXTRA_LATER: extra_val = cfg.later_init;
			default:                extra_val = 16'd0;
		endcase
	end

	assign nib_after = enable_w ? {9'd0, cfg.enable_pulse}
		: ({1'b0, cfg.exec} + {1'b0, extra_val});

	// bare latch writes carry no wait after them
	assign after_d = bare_w ? 17'd0 : nib_after;

	always_comb begin
		nib      = 4'h0;
		rs       = 1'b0;
		extra    = clews_pkg::EXTRA_NONE;
		byte_d   = 8'h00;
		before_d = 16'd0;
		bare_w   = 1'b0;
		last_d   = 1'b0;
		bl_d     = bl_q;
		unique case (q_head.kind)
			clews_pkg::KIND_INIT: begin
				nib   = clews_pkg::init_nibble(idx);
				extra = enable_w ? clews_pkg::EXTRA_NONE : clews_pkg::init_extra(idx);
				if (step_q == clews_pkg::INIT_LAST_STEP) begin
					// bare latch write, backlight forced on
					byte_d = clews_pkg::BL_ONLY_BYTE;
					bare_w = 1'b1;
					last_d = 1'b1;
					bl_d   = 1'b1;
				end else begin
					byte_d   = {nib, bl_q, enable_w, 1'b0, rs};
					before_d = (step_q == 5'd0) ? cfg.powerup : 16'd0;
				end
			end
			clews_pkg::KIND_BYTE: begin
				nib    = step_q[1] ? q_head.data[3:0] : q_head.data[7:4];
				rs     = q_head.rs;
				extra  = (step_q[1] && !enable_w) ? q_head.extra : clews_pkg::EXTRA_NONE;
				byte_d = {nib, bl_q, enable_w, 1'b0, rs};
				last_d = (step_q == clews_pkg::BYTE_LAST_STEP);
			end
			clews_pkg::KIND_BL: begin
				byte_d = {4'h0, q_head.bl, 3'b000};
				bare_w = 1'b1;
				last_d = 1'b1;
				bl_d   = q_head.bl;
			end
			default: begin
				last_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q   <= byte_d;
			before_q <= before_d;
			after_q  <= after_d;
			last_q   <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 5'd0;
			bl_q        <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q      <= last_d ? 5'd0 : step_q + 5'd1;
				bl_q        <= last_d ? bl_d : bl_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign expander_byte  = byte_q;
	assign wait_before_us = before_q;
	assign wait_after_us  = after_q;
	assign last           = last_q;

endmodule

>>> rtl/core/char_lcd_expander_write_sequencer.sv
// top level of the character lcd expander write sequencer
// depends on clews_pkg, clews_front, clews_fifo and clews_back
//
// turns lcd requests (init, character, set cursor, clear, backlight) into the
// run of port-expander bytes that drive a 4-bit character lcd, each carrying
// the microsecond waits that go before and after it. every nibble goes out as
// an enable-high write then an enable-low write. the back sequencer emits one
// write per cycle while the output is not stalled; a request has four writes for
// a character, set cursor or clear, one for a backlight change, 29 for init
// (unknown request types are dropped with no writes). the front takes a new
// request every cycle while the two-entry queue has room, so requests stack
// up behind a stalled output until the queue is full. the six wait
// registers are written through the cfg channel, which is always ready, and
// should only change while no request is in flight.
module char_lcd_expander_write_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [5:0]  column,
	input  logic        row,
	input  logic        backlight_on,
	// expander write channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  expander_byte,
	output logic [15:0] wait_before_us,
	output logic [16:0] wait_after_us,
	output logic        last,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	clews_pkg::cfg_t  cfg_q;
	clews_pkg::desc_t push_desc;
	clews_pkg::desc_t head;
	logic             q_push;
	logic             q_ready;
	logic             q_pop;
	logic             q_valid;

	// config registers, writes beyond the list are ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.powerup      <= clews_pkg::RST_POWERUP;
			cfg_q.first_init   <= clews_pkg::RST_FIRST_INIT;
			cfg_q.later_init   <= clews_pkg::RST_LATER_INIT;
			cfg_q.enable_pulse <= clews_pkg::RST_ENABLE;
			cfg_q.exec         <= clews_pkg::RST_EXEC;
			cfg_q.clear        <= clews_pkg::RST_CLEAR;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				clews_pkg::CFG_POWERUP:    cfg_q.powerup      <= cfg_data;
				clews_pkg::CFG_FIRST_INIT: cfg_q.first_init   <= cfg_data;
				clews_pkg::CFG_LATER_INIT: cfg_q.later_init   <= cfg_data;
				clews_pkg::CFG_ENABLE:     cfg_q.enable_pulse <= cfg_data[7:0];
				clews_pkg::CFG_EXEC:       cfg_q.exec         <= cfg_data;
				clews_pkg::CFG_CLEAR:      cfg_q.clear        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: accept and classify each request
	clews_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.char_code    (char_code),
		.column       (column),
		.row          (row),
		.backlight_on (backlight_on),
		.q_ready      (q_ready),
		.q_push       (q_push),
		.q_desc       (push_desc)
	);

	// queue decouples front acceptance from back sequencing
	clews_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (push_desc),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (head)
	);

	// back: step counter walks the writes, output register holds each one
	clews_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_valid        (q_valid),
		.q_head         (head),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.expander_byte  (expander_byte),
		.wait_before_us (wait_before_us),
		.wait_after_us  (wait_after_us),
		.last           (last)
	);

endmodule

>>> verif/tb_char_lcd_expander_write_sequencer.sv
// self-checking testbench for char_lcd_expander_write_sequencer
// depends on clews_pkg and the top level rtl; predicts every expander write
// of each accepted request and checks the write stream field by field
`timescale 1ns / 1ps

module tb_char_lcd_expander_write_sequencer;
	import clews_pkg::*;

	// request codes past the last known type are dropped by the block
	localparam logic [2:0] REQ_TYPE_MAX  = 3'd7;
	localparam logic [2:0] CFG_INDEX_MAX = 3'd7;

	// lcd bytes of the power-up sequence
	localparam logic [3:0] LCD_WAKE_NIBBLE  = 4'h3;
	localparam logic [3:0] LCD_4BIT_NIBBLE  = 4'h2;
	localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
	localparam logic [7:0] LCD_DISPLAY_OFF  = 8'h08;
	localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
	localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;

	// port bits beside the data nibble
	localparam logic [7:0] PORT_ENABLE = 8'h04;
	localparam logic [7:0] BL_OFF_BYTE = 8'h00;

	localparam int SETTLE_CYCLES   = 16;
	localparam int RUN_LIMIT_NS    = 40_000_000;
	localparam int RANDOM_PHASES   = 8;
	localparam int PHASE_REQUESTS  = 45;

	// one write to the port expander as the lcd should see it
	typedef struct {
		logic [7:0]  port_byte;
		logic [15:0] before_us;
		logic [16:0] after_us;
		logic        is_last;
	} port_write_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  req_type;
	logic [7:0]  char_code;
	logic [5:0]  column;
	logic        row;
	logic        backlight_on;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  expander_byte;
	logic [15:0] wait_before_us;
	logic [16:0] wait_after_us;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	// mirror of the block's registers and backlight latch
	cfg_t        lcd_cfg;
	logic        backlight_state;

	// writes predicted but not yet seen, oldest first
	port_write_t pending_writes[$];
	int          mismatch_count;

	// idle knobs, in percent of requests (sender) or cycles (sink) that start a gap
	int          send_idle_pct;
	int          sink_stall_pct;
	int          stall_left;

	char_lcd_expander_write_sequencer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.char_code     (char_code),
		.column        (column),
		.row           (row),
		.backlight_on  (backlight_on),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.expander_byte (expander_byte),
		.wait_before_us(wait_before_us),
		.wait_after_us (wait_after_us),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// write predictor
	// ------------------------------------------------------------------

	task automatic push_write(input logic [7:0] port_byte, input logic [15:0] before_us,
			input logic [16:0] after_us);
		port_write_t w;
		w.port_byte = port_byte;
		w.before_us = before_us;
		w.after_us  = after_us;
		w.is_last   = 1'b0;
		pending_writes.push_back(w);
	endtask

	// enable-high write then enable-low write of the same byte
	task automatic push_nibble(input logic [3:0] nib, input logic rs,
			input logic [15:0] before_us, input logic [15:0] extra_us);
		logic [7:0] base;
		base = {nib, backlight_state, 1'b0, 1'b0, rs};
		push_write(base | PORT_ENABLE, before_us, {9'd0, lcd_cfg.enable_pulse});
		push_write(base, 16'd0, {1'b0, lcd_cfg.exec} + {1'b0, extra_us});
	endtask

	// full lcd byte, high nibble first; the extra wait lands on the low nibble
	task automatic push_lcd_byte(input logic [7:0] data, input logic rs,
			input logic [15:0] extra_us);
		push_nibble(data[7:4], rs, 16'd0, 16'd0);
		push_nibble(data[3:0], rs, 16'd0, extra_us);
	endtask

	task automatic predict_lcd_writes(input logic [2:0] kind, input logic [7:0] ch,
			input logic [5:0] col, input logic r, input logic bl);
		int first_new;
		first_new = pending_writes.size();
		case (kind)
			REQ_INIT: begin
				// init nibbles use the backlight as it was; it is forced on at the end
				push_nibble(LCD_WAKE_NIBBLE, 1'b0, lcd_cfg.powerup, lcd_cfg.first_init);
				push_nibble(LCD_WAKE_NIBBLE, 1'b0, 16'd0, lcd_cfg.later_init);
				push_nibble(LCD_WAKE_NIBBLE, 1'b0, 16'd0, lcd_cfg.later_init);
				push_nibble(LCD_4BIT_NIBBLE, 1'b0, 16'd0, lcd_cfg.later_init);
				push_lcd_byte(LCD_FUNCTION_SET, 1'b0, lcd_cfg.exec);
				push_lcd_byte(LCD_DISPLAY_OFF, 1'b0, lcd_cfg.exec);
				push_lcd_byte(CMD_CLEAR, 1'b0, lcd_cfg.clear);
				push_lcd_byte(LCD_ENTRY_MODE, 1'b0, lcd_cfg.exec);
				push_lcd_byte(LCD_DISPLAY_ON, 1'b0, lcd_cfg.exec);
				backlight_state = 1'b1;
				push_write(BL_ONLY_BYTE, 16'd0, 17'd0);
			end
			REQ_CHAR:   push_lcd_byte(ch, 1'b1, 16'd0);
			// address is column plus 0x40 on the second row
			REQ_CURSOR: push_lcd_byte(CMD_SET_DDRAM | {1'b0, r, col}, 1'b0, lcd_cfg.exec);
			REQ_CLEAR:  push_lcd_byte(CMD_CLEAR, 1'b0, lcd_cfg.clear);
			REQ_BACKLIGHT: begin
				backlight_state = bl;
				push_write(bl ? BL_ONLY_BYTE : BL_OFF_BYTE, 16'd0, 17'd0);
			end
			default: ;  // unknown request types produce nothing
		endcase
		if (pending_writes.size() > first_new)
			pending_writes[$].is_last = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// idling on both sides
	// ------------------------------------------------------------------

	// mostly short gaps, now and then a long one
	function automatic int pick_idle(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 10);
		return $urandom_range(3, 1);
	endfunction

	// output stall generator, changes only on the falling edge
	always @(negedge clk) begin
		if (stall_left == 0)
			stall_left = pick_idle(sink_stall_pct);
		if (stall_left != 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else begin
			out_ready = 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// request and config drivers, entered just after a falling edge
	// ------------------------------------------------------------------

	task automatic send_request(input logic [2:0] kind, input logic [7:0] ch,
			input logic [5:0] col, input logic r, input logic bl);
		int gap;
		gap = pick_idle(send_idle_pct);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     = 1'b1;
		req_type     = kind;
		char_code    = ch;
		column       = col;
		row          = r;
		backlight_on = bl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// request taken at this edge
		predict_lcd_writes(kind, ch, col, r, bl);
		@(negedge clk);
	endtask

	// drop valid, let every predicted write drain, then give the block time to settle
	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_writes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_POWERUP:    lcd_cfg.powerup      = data;
			CFG_FIRST_INIT: lcd_cfg.first_init   = data;
			CFG_LATER_INIT: lcd_cfg.later_init   = data;
			CFG_ENABLE:     lcd_cfg.enable_pulse = data[7:0];
			CFG_EXEC:       lcd_cfg.exec         = data;
			CFG_CLEAR:      lcd_cfg.clear        = data;
			default: ;  // indexes past the list are ignored
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// full register set; the enable register gets junk in its unused upper bits
	task automatic load_config(input cfg_t c);
		logic [7:0] junk;
		junk = 8'($urandom);
		wait_idle();
		write_cfg_reg(CFG_POWERUP, c.powerup);
		write_cfg_reg(CFG_FIRST_INIT, c.first_init);
		write_cfg_reg(CFG_LATER_INIT, c.later_init);
		write_cfg_reg(CFG_ENABLE, {junk, c.enable_pulse});
		write_cfg_reg(CFG_EXEC, c.exec);
		write_cfg_reg(CFG_CLEAR, c.clear);
	endtask

	// each register at zero, at its top or anywhere in between
	function automatic logic [15:0] pick_reg_value();
		case ($urandom_range(3))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random_request(output bit known);
		int unsigned pick;
		logic [2:0]  kind;
		logic [7:0]  ch;
		logic [5:0]  col;
		logic        r;
		logic        bl;
		pick = $urandom_range(99);
		if (pick < 45)
			kind = REQ_CHAR;
		else if (pick < 65)
			kind = REQ_CURSOR;
		else if (pick < 75)
			kind = REQ_CLEAR;
		else if (pick < 90)
			kind = REQ_BACKLIGHT;
		else if (pick < 95)
			kind = REQ_INIT;
		else
			kind = 3'($urandom_range(REQ_TYPE_MAX, REQ_BACKLIGHT + 3'd1));
		ch  = 8'($urandom);
		col = 6'($urandom);
		r   = 1'($urandom);
		bl  = 1'($urandom);
		send_request(kind, ch, col, r, bl);
		known = (kind <= REQ_BACKLIGHT);
	endtask

	// ------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string field, input int unsigned want,
			input int unsigned got);
		mismatch_count++;
		$display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
			$time, field, want, got);
	endtask

	always @(posedge clk) begin : write_checker
		port_write_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_writes.size() == 0) begin
				report_mismatch("unexpected write, expander_byte", 0, expander_byte);
			end else begin
				want = pending_writes.pop_front();
				if (expander_byte !== want.port_byte)
					report_mismatch("expander_byte", want.port_byte, expander_byte);
				if (wait_before_us !== want.before_us)
					report_mismatch("wait_before_us", want.before_us, wait_before_us);
				if (wait_after_us !== want.after_us)
					report_mismatch("wait_after_us", want.after_us, wait_after_us);
				if (last !== want.is_last)
					report_mismatch("last", want.is_last, last);
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// every request type at reset settings, field extremes, backlight off and on
	task automatic test_directed_requests();
		send_idle_pct  = 20;
		sink_stall_pct = 20;
		send_request(REQ_INIT, 8'h00, 6'd0, 1'b0, 1'b0);
		send_request(REQ_CHAR, 8'h00, 6'd63, 1'b1, 1'b0);
		send_request(REQ_CHAR, 8'hFF, 6'd0, 1'b0, 1'b1);
		send_request(REQ_CHAR, 8'hA5, 6'd21, 1'b1, 1'b0);
		send_request(REQ_CURSOR, 8'hFF, 6'd0, 1'b0, 1'b1);
		send_request(REQ_CURSOR, 8'h00, 6'd63, 1'b1, 1'b0);
		send_request(REQ_CURSOR, 8'h5A, 6'd63, 1'b0, 1'b0);
		send_request(REQ_CURSOR, 8'h5A, 6'd0, 1'b1, 1'b1);
		send_request(REQ_CLEAR, 8'hFF, 6'd63, 1'b1, 1'b0);
		// backlight off must show up in the following writes
		send_request(REQ_BACKLIGHT, 8'hFF, 6'd63, 1'b1, 1'b0);
		send_request(REQ_CHAR, 8'h5A, 6'd0, 1'b0, 1'b1);
		send_request(REQ_CURSOR, 8'h00, 6'd42, 1'b1, 1'b1);
		send_request(REQ_BACKLIGHT, 8'h00, 6'd0, 1'b0, 1'b1);
		send_request(REQ_BACKLIGHT, 8'h00, 6'd0, 1'b0, 1'b0);
		// init runs with the backlight off and turns it back on at the end
		send_request(REQ_INIT, 8'hFF, 6'd63, 1'b1, 1'b0);
		send_request(REQ_CHAR, 8'h3C, 6'd9, 1'b0, 1'b0);
		// unknown types, with char, column and row high, must be dropped silently
		send_request(REQ_BACKLIGHT + 3'd1, 8'hFF, 6'd63, 1'b1, 1'b1);
		send_request(REQ_TYPE_MAX - 3'd1, 8'hFF, 6'd63, 1'b1, 1'b0);
		send_request(REQ_TYPE_MAX, 8'hFF, 6'd63, 1'b1, 1'b1);
		send_request(REQ_CLEAR, 8'h00, 6'd0, 1'b0, 1'b0);
		wait_idle();
	endtask

	// all registers at their top, then all at zero, then writes past the list
	task automatic test_config_extremes();
		cfg_t c;
		send_idle_pct  = 0;
		sink_stall_pct = 0;
		c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF};
		load_config(c);
		send_request(REQ_INIT, 8'h00, 6'd0, 1'b0, 1'b0);
		send_request(REQ_CLEAR, 8'h00, 6'd0, 1'b0, 1'b0);
		send_request(REQ_CURSOR, 8'h00, 6'd63, 1'b1, 1'b0);
		send_request(REQ_CHAR, 8'hFF, 6'd0, 1'b0, 1'b0);
		c = '{16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000};
		load_config(c);
		send_request(REQ_INIT, 8'h00, 6'd0, 1'b0, 1'b0);
		send_request(REQ_CLEAR, 8'h00, 6'd0, 1'b0, 1'b0);
		send_request(REQ_CURSOR, 8'h00, 6'd0, 1'b0, 1'b0);
		send_request(REQ_CHAR, 8'h81, 6'd0, 1'b0, 1'b0);
		// writes past the register list must leave every register alone
		wait_idle();
		write_cfg_reg(CFG_CLEAR + 3'd1, 16'hFFFF);
		write_cfg_reg(CFG_INDEX_MAX, 16'hFFFF);
		send_request(REQ_INIT, 8'h00, 6'd0, 1'b0, 1'b0);
		send_request(REQ_CHAR, 8'h7E, 6'd0, 1'b0, 1'b0);
		c = '{RST_POWERUP, RST_FIRST_INIT, RST_LATER_INIT, RST_ENABLE, RST_EXEC, RST_CLEAR};
		load_config(c);
	endtask

	// phases of random traffic, each with its own register set and idle mix
	task automatic test_random_traffic();
		cfg_t c;
		int   sent;
		bit   known;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			c.powerup      = pick_reg_value();
			c.first_init   = pick_reg_value();
			c.later_init   = pick_reg_value();
			c.enable_pulse = 8'(pick_reg_value());
			c.exec         = pick_reg_value();
			c.clear        = pick_reg_value();
			load_config(c);
			// some phases run flat out on one or both sides
			send_idle_pct  = ($urandom_range(2) == 0) ? 0 : $urandom_range(50, 10);
			sink_stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(50, 10);
			sent = 0;
			while (sent < PHASE_REQUESTS) begin
				send_random_request(known);
				if (known)
					sent++;
			end
		end
		wait_idle();
	endtask

	// heavy output stalls so requests pile up in the queue, with a full drain midway
	task automatic test_output_backpressure();
		bit known;
		send_idle_pct  = 0;
		sink_stall_pct = 70;
		repeat (30) send_random_request(known);
		// hold the sender until every write has come out
		in_valid = 1'b0;
		while (pending_writes.size() != 0)
			@(negedge clk);
		repeat (30) send_random_request(known);
		sink_stall_pct = 0;
		repeat (20) send_random_request(known);
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// run control
	// ------------------------------------------------------------------

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		req_type       = REQ_INIT;
		char_code      = 8'h00;
		column         = 6'd0;
		row            = 1'b0;
		backlight_on   = 1'b0;
		out_ready      = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_POWERUP;
		cfg_data       = 16'h0000;
		stall_left     = 0;
		send_idle_pct  = 0;
		sink_stall_pct = 0;
		mismatch_count = 0;
		lcd_cfg = '{RST_POWERUP, RST_FIRST_INIT, RST_LATER_INIT, RST_ENABLE, RST_EXEC,
			RST_CLEAR};
		backlight_state = 1'b1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_requests();
		test_config_extremes();
		test_random_traffic();
		test_output_backpressure();

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#(RUN_LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

endmodule
